// ===== rtl/i2c_eeprom_word_access_sequencer_assert.svh =====
// Assertion macros for the I2C EEPROM word access sequencer.
// Included by the top level, which checks its own logic; depends on nothing.
`ifndef I2C_EEPROM_WORD_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_EEPROM_WORD_ACCESS_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CEWS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CEWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cews_pkg.sv =====
// Shared types and codes for the I2C EEPROM word access sequencer.
// Used by the bus channel interface and the top level; depends on nothing.
package i2cews_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_REPLY = 2'd2;

  localparam logic [3:0] CTRL_BASE = 4'hA;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4,
    OP_NACK  = 3'd5,
    OP_DONE  = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CTRL_ACK = 4'd1,
    PH_ADDR     = 4'd2,
    PH_DATA_LO  = 4'd3,
    PH_DATA_HI  = 4'd4,
    PH_READ_CMD = 4'd5,
    PH_READ_LO  = 4'd6,
    PH_READ_HI  = 4'd7
  } phase_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] word;
    logic        last;
  } result_t;

endpackage

// ===== rtl/i2cews_in_if.sv =====
// Request and reply channel of the I2C EEPROM word access sequencer.
// Depends on nothing.
interface i2cews_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [10:0] word_address;
  logic [15:0] write_word;
  logic        reply_nack;
  logic [7:0]  reply_byte;

  modport source (output valid, action, word_address, write_word, reply_nack, reply_byte,
                  input ready);
  modport sink (input valid, action, word_address, write_word, reply_nack, reply_byte,
                output ready);
endinterface

// ===== rtl/i2cews_out_if.sv =====
// Bus primitive channel of the I2C EEPROM word access sequencer.
// Depends on i2cews_pkg for the primitive code type.
interface i2cews_out_if;
  logic              valid;
  logic              ready;
  i2cews_pkg::op_t   bus_op;
  logic [7:0]        bus_byte;
  logic [15:0]       read_word;
  logic              last;

  modport source (output valid, bus_op, bus_byte, read_word, last, input ready);
  modport sink (input valid, bus_op, bus_byte, read_word, last, output ready);
endinterface

// ===== rtl/i2c_eeprom_word_access_sequencer.sv =====
// Top level of the I2C EEPROM word access sequencer.
// Depends on i2cews_pkg, i2cews_in_if, i2cews_out_if and the assertion macro header.
//
//   channel  direction  carries
//   host     in         read/write requests and replies from the bus engine
//   bus      out        one bus primitive per transfer, last marks the final one of an item
//
// An item is taken and its up to three primitives are placed in a result queue in the
// same cycle; the queue then issues one primitive per cycle while bus is ready. A new item
// is taken when the queue is empty or is giving up its final entry. A stall on bus holds
// the queue and host waits. Reset is synchronous and empties the queue and returns the
// sequence to idle.
`include "i2c_eeprom_word_access_sequencer_assert.svh"

module i2c_eeprom_word_access_sequencer (
  input  logic           clk,
  input  logic           rst,
  i2cews_in_if.sink      host,
  i2cews_out_if.source   bus
);

  i2cews_pkg::phase_t  phase;
  i2cews_pkg::phase_t  phase_next;
  logic                is_write;
  logic                is_write_next;
  logic [10:0]         saved_address;
  logic [10:0]         saved_address_next;
  logic [15:0]         saved_data;
  logic [15:0]         saved_data_next;
  logic [7:0]          low_byte;
  logic [7:0]          low_byte_next;

  i2cews_pkg::result_t slots [3];
  i2cews_pkg::result_t res [3];
  logic [1:0]          count;
  logic [1:0]          n_res;
  logic                take;
  logic                pop;
  logic                idle;
  logic                is_req;
  logic [10:0]         addr_eff;
  logic [7:0]          ctrl_byte;

  function automatic i2cews_pkg::result_t mk(i2cews_pkg::op_t op, logic [7:0] data,
                                             logic [15:0] word, logic last);
    i2cews_pkg::result_t r;
    r.op   = op;
    r.data = data;
    r.word = word;
    r.last = last;
    return r;
  endfunction

  assign take     = host.valid && host.ready;
  assign pop      = bus.valid && bus.ready;
  assign idle     = (phase == i2cews_pkg::PH_IDLE) || (phase > i2cews_pkg::PH_READ_HI);
  assign is_req   = (host.action == i2cews_pkg::ACT_READ) ||
                    (host.action == i2cews_pkg::ACT_WRITE);
  assign addr_eff = is_req ? host.word_address : saved_address;
  assign ctrl_byte = {i2cews_pkg::CTRL_BASE, addr_eff[10:8], 1'b0};

  assign host.ready = (count == 2'd0) || ((count == 2'd1) && bus.ready);

  // Next state of the sequence.
  always_comb begin
    phase_next         = phase;
    is_write_next      = is_write;
    saved_address_next = saved_address;
    saved_data_next    = saved_data;
    low_byte_next      = low_byte;
    if (take) begin
      if (is_req && idle) begin
        is_write_next      = (host.action == i2cews_pkg::ACT_WRITE);
        saved_address_next = host.word_address;
        saved_data_next    = host.write_word;
        phase_next         = i2cews_pkg::PH_CTRL_ACK;
      end else if ((host.action == i2cews_pkg::ACT_REPLY) && !idle) begin
        unique case (phase)
          i2cews_pkg::PH_CTRL_ACK: begin
            if (!host.reply_nack) begin
              phase_next = i2cews_pkg::PH_ADDR;
            end
          end
          i2cews_pkg::PH_ADDR: begin
            phase_next = is_write ? i2cews_pkg::PH_DATA_LO : i2cews_pkg::PH_READ_CMD;
          end
          i2cews_pkg::PH_DATA_LO:  phase_next = i2cews_pkg::PH_DATA_HI;
          i2cews_pkg::PH_DATA_HI:  phase_next = i2cews_pkg::PH_IDLE;
          i2cews_pkg::PH_READ_CMD: phase_next = i2cews_pkg::PH_READ_LO;
          i2cews_pkg::PH_READ_LO: begin
            low_byte_next = host.reply_byte;
            phase_next    = i2cews_pkg::PH_READ_HI;
          end
          i2cews_pkg::PH_READ_HI:  phase_next = i2cews_pkg::PH_IDLE;
          default:                 phase_next = i2cews_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Primitives caused by the item on host.
  always_comb begin
    n_res  = 2'd0;
    res[0] = mk(i2cews_pkg::OP_START, 8'd0, 16'd0, 1'b0);
    res[1] = mk(i2cews_pkg::OP_START, 8'd0, 16'd0, 1'b0);
    res[2] = mk(i2cews_pkg::OP_START, 8'd0, 16'd0, 1'b0);
    if (is_req && idle) begin
      n_res  = 2'd2;
      res[1] = mk(i2cews_pkg::OP_WRITE, ctrl_byte, 16'd0, 1'b1);
    end else if ((host.action == i2cews_pkg::ACT_REPLY) && !idle) begin
      unique case (phase)
        i2cews_pkg::PH_CTRL_ACK: begin
          if (host.reply_nack) begin
            n_res  = 2'd3;
            res[0] = mk(i2cews_pkg::OP_STOP, 8'd0, 16'd0, 1'b0);
            res[2] = mk(i2cews_pkg::OP_WRITE, ctrl_byte, 16'd0, 1'b1);
          end else begin
            n_res  = 2'd1;
            res[0] = mk(i2cews_pkg::OP_WRITE, saved_address[7:0], 16'd0, 1'b1);
          end
        end
        i2cews_pkg::PH_ADDR: begin
          if (is_write) begin
            n_res  = 2'd1;
            res[0] = mk(i2cews_pkg::OP_WRITE, saved_data[7:0], 16'd0, 1'b1);
          end else begin
            n_res  = 2'd3;
            res[0] = mk(i2cews_pkg::OP_STOP, 8'd0, 16'd0, 1'b0);
            res[2] = mk(i2cews_pkg::OP_WRITE, ctrl_byte | 8'd1, 16'd0, 1'b1);
          end
        end
        i2cews_pkg::PH_DATA_LO: begin
          n_res  = 2'd1;
          res[0] = mk(i2cews_pkg::OP_WRITE, saved_data[15:8], 16'd0, 1'b1);
        end
        i2cews_pkg::PH_DATA_HI: begin
          n_res  = 2'd2;
          res[0] = mk(i2cews_pkg::OP_STOP, 8'd0, 16'd0, 1'b0);
          res[1] = mk(i2cews_pkg::OP_DONE, 8'd0, 16'd0, 1'b1);
        end
        i2cews_pkg::PH_READ_CMD: begin
          n_res  = 2'd1;
          res[0] = mk(i2cews_pkg::OP_READ, 8'd0, 16'd0, 1'b1);
        end
        i2cews_pkg::PH_READ_LO: begin
          n_res  = 2'd2;
          res[0] = mk(i2cews_pkg::OP_ACK, 8'd0, 16'd0, 1'b0);
          res[1] = mk(i2cews_pkg::OP_READ, 8'd0, 16'd0, 1'b1);
        end
        i2cews_pkg::PH_READ_HI: begin
          n_res  = 2'd3;
          res[0] = mk(i2cews_pkg::OP_NACK, 8'd0, 16'd0, 1'b0);
          res[1] = mk(i2cews_pkg::OP_STOP, 8'd0, 16'd0, 1'b0);
          res[2] = mk(i2cews_pkg::OP_DONE, 8'd0, {host.reply_byte, low_byte}, 1'b1);
        end
        default: n_res = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cews_pkg::PH_IDLE;
      is_write      <= 1'b0;
      saved_address <= 11'd0;
      saved_data    <= 16'd0;
      low_byte      <= 8'd0;
      count         <= 2'd0;
    end else begin
      phase         <= phase_next;
      is_write      <= is_write_next;
      saved_address <= saved_address_next;
      saved_data    <= saved_data_next;
      low_byte      <= low_byte_next;
      if (take) begin
        count <= n_res;
      end else if (pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slots[0] <= res[0];
      slots[1] <= res[1];
      slots[2] <= res[2];
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  assign bus.valid     = (count != 2'd0);
  assign bus.bus_op    = slots[0].op;
  assign bus.bus_byte  = slots[0].data;
  assign bus.read_word = slots[0].word;
  assign bus.last      = slots[0].last;

  `I2CEWS_ASSERT_NEXT(a_load_shows, clk, rst, take && (n_res != 2'd0), bus.valid,
                      "primitives of a taken item are not offered")
  `I2CEWS_ASSERT_SAME(a_last_final, clk, rst, bus.valid, bus.last == (count == 2'd1),
                      "last does not mark the final queued primitive")
  `I2CEWS_ASSERT_NEXT(a_idle_reply, clk, rst,
                      take && (host.action == i2cews_pkg::ACT_REPLY) &&
                      (phase == i2cews_pkg::PH_IDLE),
                      !bus.valid && (phase == i2cews_pkg::PH_IDLE),
                      "reply while idle caused primitives")
  `I2CEWS_ASSERT_SAME(a_done_last, clk, rst,
                      bus.valid && (bus.bus_op == i2cews_pkg::OP_DONE),
                      bus.last && (phase == i2cews_pkg::PH_IDLE),
                      "done is not final or sequence not idle")

endmodule
